// File: rtl/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types, codes and constants of the button gesture recognizer.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int HistoryDepth = 30;

  localparam int SampleW  = 12;
  localparam int GainW    = 13;
  localparam int OffsetW  = 10;
  localparam int TicksW   = 6;
  localparam int PosW     = 5;
  localparam int ActionW  = 4;
  localparam int BtnW     = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int AdcShift = 12;
  localparam int ProdW    = SampleW + GainW;
  localparam int ScaledW  = ProdW - AdcShift;
  localparam int MvW      = ScaledW + 2;

  localparam int ClickQuiet = 4;

  localparam logic [GainW-1:0]          GainReset    = 13'd3350;
  localparam logic signed [OffsetW-1:0] OffsetReset  = -10'sd50;
  localparam logic [TicksW-1:0]         LongReset    = 6'd10;
  localparam logic [TicksW-1:0]         LongLongReset = 6'd30;
  localparam logic [PosW-1:0]           RelPosReset  = 5'd8;
  localparam logic [TicksW-1:0]         HoldReset    = 6'd30;
  localparam logic [TicksW-1:0]         HoldMax      = 6'd63;

  localparam logic signed [MvW-1:0] CenterHi = 15'sd100;
  localparam logic signed [MvW-1:0] DLo      = 15'sd142;
  localparam logic signed [MvW-1:0] DHi      = 15'sd238;
  localparam logic signed [MvW-1:0] PlusLo   = 15'sd240;
  localparam logic signed [MvW-1:0] PlusHi   = 15'sd400;
  localparam logic signed [MvW-1:0] MinusLo  = 15'sd435;
  localparam logic signed [MvW-1:0] MinusHi  = 15'sd725;

  localparam logic [CfgIdxW-1:0] REG_ADC_GAIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADC_OFFSET    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_PUSH     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG_LONG     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_CHECK = 3'd4;

  typedef enum logic [BtnW-1:0] {
    BTN_OPEN   = 3'd0,
    BTN_CENTER = 3'd1,
    BTN_D      = 3'd2,
    BTN_PLUS   = 3'd3,
    BTN_MINUS  = 3'd4
  } btn_e;

  typedef enum logic [ActionW-1:0] {
    ACT_SINGLE     = 4'd0,
    ACT_DOUBLE     = 4'd1,
    ACT_TRIPLE     = 4'd2,
    ACT_PLUS       = 4'd3,
    ACT_MINUS      = 4'd4,
    ACT_LONG       = 4'd5,
    ACT_PLUS_LONG  = 4'd6,
    ACT_MINUS_LONG = 4'd7,
    ACT_LONG_LONG  = 4'd8
  } act_e;

  typedef struct packed {
    btn_e button;
    logic unit;
  } cls_res_t;

endpackage

// File: rtl/gbr_ram.sv
// ----------------------------------------------------------------------------
// gbr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gbr_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gbr_classify.sv
// ----------------------------------------------------------------------------
// gbr_classify
// Two-stage sample scaler and band classifier, merged with the switch pins.
// ----------------------------------------------------------------------------
module gbr_classify
  import gbr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SampleW-1:0]        adc_sample_i,
  input  logic                      plus_switch_level_i,
  input  logic                      minus_switch_level_i,
  input  logic [GainW-1:0]          adc_gain_i,
  input  logic signed [OffsetW-1:0] adc_offset_i,
  output logic                      done_o,
  output cls_res_t                  res_o
);

  logic [ProdW-1:0]     prod_q;
  btn_e                 sw_q, sw_d;
  logic                 v1_q, v2_q;
  cls_res_t             res_q, res_d;
  logic [ScaledW-1:0]   scaled;
  logic signed [MvW-1:0] mv;
  btn_e                 hp;

  always_comb begin
    if (!plus_switch_level_i) begin
      sw_d = BTN_PLUS;
    end else if (!minus_switch_level_i) begin
      sw_d = BTN_MINUS;
    end else begin
      sw_d = BTN_OPEN;
    end
  end

  assign scaled = prod_q[ProdW-1:AdcShift];
  assign mv     = $signed({2'b00, scaled}) + MvW'(adc_offset_i);

  always_comb begin
    priority if (mv < CenterHi) begin
      hp = BTN_CENTER;
    end else if (mv >= DLo && mv < DHi) begin
      hp = BTN_D;
    end else if (mv >= PlusLo && mv < PlusHi) begin
      hp = BTN_PLUS;
    end else if (mv >= MinusLo && mv < MinusHi) begin
      hp = BTN_MINUS;
    end else begin
      hp = BTN_OPEN;
    end
  end

  always_comb begin
    priority if (hp == BTN_CENTER) begin
      res_d.button = BTN_CENTER;
    end else if (hp == BTN_D) begin
      res_d.button = BTN_D;
    end else if (hp == BTN_PLUS || sw_q == BTN_PLUS) begin
      res_d.button = BTN_PLUS;
    end else if (hp == BTN_MINUS || sw_q == BTN_MINUS) begin
      res_d.button = BTN_MINUS;
    end else begin
      res_d.button = BTN_OPEN;
    end
    res_d.unit = (res_d.button != sw_q);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= ProdW'(adc_sample_i) * ProdW'(adc_gain_i);
      sw_q   <= sw_d;
    end
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  assign done_o = v2_q;
  assign res_o  = res_q;

endmodule

// File: rtl/button_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// button_gesture_recognizer
// Headphone-remote and push-switch gesture recognizer with RAM-held history.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A beat passes through the classifier and
// the H0 read, then the release position check when it is needed and a click
// scan when a center release is found, and commits in the final state. The next
// beat is taken in the cycle after the commit. The button history lives in a
// single-read-port RAM (a ring with a head pointer and a fill count, entries
// past the fill count read as open), and the scan walks it one entry per
// cycle. A finished event waits in an output register, so the next beat is
// accepted while it is still stalled; a beat that raises another event holds
// at its commit until the waiting one is taken. No clearing pass is needed
// after reset.
module button_gesture_recognizer
  import gbr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistoryDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SampleW-1:0]   adc_sample_i,
  input  logic                 plus_switch_level_i,
  input  logic                 minus_switch_level_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ActionW-1:0]   action_o,
  output logic                 source_unit_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = ((FW > PosW) ? FW : PosW) + 1;
  localparam logic [AW-1:0] LastAddr = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FullFill = FW'(HISTORY_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLS  = 3'd1;
  localparam logic [2:0] ST_H0   = 3'd2;
  localparam logic [2:0] ST_RCP  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [GainW-1:0]          gain_q;
  logic signed [OffsetW-1:0] offset_q;
  logic [TicksW-1:0]         lpt_q, llpt_q;
  logic [PosW-1:0]           rcp_q;

  logic [AW-1:0]     head_q, head_d, head_nxt;
  logic [FW-1:0]     fill_q, fill_d;
  logic [TicksW-1:0] hold_q, hold_d, hold_inc;
  btn_e              button_q, h0_q, prev_q;
  logic              unit_q;
  logic [AW-1:0]     idx_q, scan_addr_q, scan_addr_nxt;
  logic              fallen_q;
  logic [FW-1:0]     count_q;

  logic              out_valid_q;
  act_e              action_q;
  logic              source_unit_q;

  logic              in_accept;
  logic              cls_done;
  cls_res_t          cls_res;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BtnW-1:0]   rd_data;
  btn_e              rd_btn;
  logic              wr_en;

  logic [CW-1:0]     rcp_diff;
  logic [AW-1:0]     rcp_addr;
  logic              rcp_in_range, rcp_valid, need_rcp, idx_valid;
  btn_e              scan_btn;

  logic              has_res, clr, commit;
  act_e              act;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GainReset;
      offset_q <= OffsetReset;
      lpt_q    <= LongReset;
      llpt_q   <= LongLongReset;
      rcp_q    <= RelPosReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ADC_GAIN:      gain_q   <= cfg_wdata_i[GainW-1:0];
        REG_ADC_OFFSET:    offset_q <= $signed(cfg_wdata_i[OffsetW-1:0]);
        REG_LONG_PUSH:     lpt_q    <= cfg_wdata_i[TicksW-1:0];
        REG_LONG_LONG:     llpt_q   <= cfg_wdata_i[TicksW-1:0];
        REG_RELEASE_CHECK: rcp_q    <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  gbr_classify u_classify (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (in_accept),
    .adc_sample_i         (adc_sample_i),
    .plus_switch_level_i  (plus_switch_level_i),
    .minus_switch_level_i (minus_switch_level_i),
    .adc_gain_i           (gain_q),
    .adc_offset_i         (offset_q),
    .done_o               (cls_done),
    .res_o                (cls_res)
  );

  gbr_ram #(
    .Width (BtnW),
    .Depth (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (head_nxt),
    .wdata_i (button_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_btn = btn_e'(rd_data);

  // ring addressing: entry i lives at head - i
  assign head_nxt      = (head_q == LastAddr) ? '0 : head_q + AW'(1);
  assign scan_addr_nxt = (scan_addr_q == '0) ? LastAddr : scan_addr_q - AW'(1);
  assign rcp_diff      = CW'(head_q) - CW'(rcp_q);
  assign rcp_addr      = rcp_diff[CW-1] ? AW'(rcp_diff + CW'(HISTORY_DEPTH))
                                        : rcp_diff[AW-1:0];
  assign rcp_in_range  = CW'(rcp_q) < CW'(HISTORY_DEPTH);
  assign rcp_valid     = CW'(rcp_q) < CW'(fill_q);
  assign need_rcp      = (button_q == BTN_OPEN) && !(hold_q > lpt_q) && rcp_in_range;
  assign idx_valid     = CW'(idx_q) < CW'(fill_q);
  assign scan_btn      = idx_valid ? rd_btn : BTN_OPEN;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_q;
    unique case (state_q)
      ST_CLS: begin
        rd_en = cls_done;
      end
      ST_H0: begin
        rd_en   = need_rcp;
        rd_addr = rcp_addr;
      end
      ST_RCP: begin
        rd_en = 1'b1;
      end
      ST_SCAN: begin
        rd_en   = (idx_q != LastAddr);
        rd_addr = scan_addr_nxt;
      end
      default: ;
    endcase
  end

  assign hold_inc = (hold_q != HoldMax) ? hold_q + TicksW'(1) : hold_q;

  always_comb begin
    has_res = 1'b0;
    act     = ACT_SINGLE;
    hold_d  = hold_q;
    clr     = 1'b0;
    if (button_q == BTN_OPEN) begin
      hold_d = '0;
      clr    = (hold_q > lpt_q) || (count_q != '0);
      if (count_q >= FW'(1) && count_q <= FW'(3)) begin
        has_res = 1'b1;
        act     = act_e'(ActionW'(count_q - FW'(1)));
      end
    end else if (h0_q == BTN_OPEN) begin
      if (button_q == BTN_D || button_q == BTN_PLUS) begin
        has_res = 1'b1;
        act     = ACT_PLUS;
      end else if (button_q == BTN_MINUS) begin
        has_res = 1'b1;
        act     = ACT_MINUS;
      end
    end else if (hold_q == lpt_q) begin
      has_res = 1'b1;
      if (button_q == BTN_CENTER) begin
        act    = ACT_LONG;
        hold_d = hold_inc;
      end else if (button_q == BTN_D || button_q == BTN_PLUS) begin
        act = ACT_PLUS_LONG;
      end else begin
        act = ACT_MINUS_LONG;
      end
    end else if (hold_q == llpt_q) begin
      if (button_q == BTN_CENTER) begin
        has_res = 1'b1;
        act     = ACT_LONG_LONG;
      end
      hold_d = hold_inc;
    end else if (button_q == h0_q) begin
      hold_d = hold_inc;
    end
  end

  // hold the commit while a new event would overwrite a stalled one
  assign commit = (state_q == ST_FIN) && !(has_res && out_valid_q && out_stall_i);
  assign wr_en  = commit;
  assign head_d = head_nxt;
  assign fill_d = clr ? FW'(1) : ((fill_q == FullFill) ? fill_q : fill_q + FW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_CLS;
      ST_CLS:  if (cls_done) state_d = ST_H0;
      ST_H0:   state_d = need_rcp ? ST_RCP : ST_FIN;
      ST_RCP:  state_d = (rcp_valid && rd_btn == BTN_CENTER) ? ST_SCAN : ST_FIN;
      ST_SCAN: begin
        if (idx_q == LastAddr) begin
          state_d = ST_FIN;
        end else if (idx_q < AW'(ClickQuiet) && scan_btn != BTN_OPEN) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      hold_q      <= HoldReset;
      count_q     <= '0;
      fallen_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLS: begin
          count_q  <= '0;
          fallen_q <= 1'b0;
        end
        ST_SCAN: begin
          if (idx_q < AW'(ClickQuiet)) begin
            if (scan_btn != BTN_OPEN) begin
              count_q <= '0;
            end
          end else if (!fallen_q && prev_q == BTN_OPEN && scan_btn == BTN_CENTER) begin
            fallen_q <= 1'b1;
          end else if (fallen_q && prev_q == BTN_CENTER && scan_btn == BTN_OPEN) begin
            fallen_q <= 1'b0;
            count_q  <= count_q + FW'(1);
          end
        end
        ST_FIN: begin
          if (commit) begin
            head_q <= head_d;
            fill_q <= fill_d;
            hold_q <= hold_d;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLS && cls_done) begin
      button_q <= cls_res.button;
      unit_q   <= cls_res.unit;
    end
    if (state_q == ST_H0) begin
      h0_q <= (fill_q != '0) ? rd_btn : BTN_OPEN;
    end
    if (state_q == ST_RCP) begin
      idx_q       <= '0;
      scan_addr_q <= head_q;
    end
    if (state_q == ST_SCAN) begin
      prev_q      <= scan_btn;
      idx_q       <= idx_q + AW'(1);
      scan_addr_q <= scan_addr_nxt;
    end
    if (commit && has_res) begin
      action_q      <= act;
      source_unit_q <= unit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign source_unit_o = source_unit_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("history fill count exceeds depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastAddr)
    else $error("history head pointer out of range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= LastAddr)
    else $error("scan index out of range");

  a_click_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (action_q == ACT_SINGLE || action_q == ACT_DOUBLE ||
                    action_q == ACT_TRIPLE) |-> !source_unit_q)
    else $error("click event not credited to switch side");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> state_q == ST_IDLE)
    else $error("commit did not return to idle");

endmodule

// File: test/button_gesture_recognizer_test.sv
// ----------------------------------------------------------------------------
// button_gesture_recognizer_test
// Drives button ticks through the gesture recognizer and checks every event
// against a tick-by-tick predictor of history, hold count and bands. A short
// table of directed ticks runs first, then phases of random gestures (click
// bursts, holds, taps and noise) under several register settings, with
// random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module button_gesture_recognizer_test;
  import gbr_pkg::*;

  typedef struct {
    act_e act;
    logic unit;
  } gesture_evt_t;

  typedef enum {ROW_BY_MODEL, ROW_NO_EVENT, ROW_EVENT} row_chk_e;

  typedef struct {
    logic [SampleW-1:0] sample;
    logic               plus_lvl;
    logic               minus_lvl;
    row_chk_e           chk;
    act_e               act;
    logic               unit;
  } tick_row_t;

  typedef struct {
    int gain;
    int offset;
    int long_t;
    int long_long_t;
    int rel_pos;
    int beats;
  } phase_cfg_t;

  localparam int SOpen   = 4095;
  localparam int SCenter = 0;
  localparam int SD      = 240;
  localparam int SPlus   = 428;
  localparam int SMinus  = 795;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  adc_sample_i = '0;
  logic                plus_switch_level_i = 1'b1;
  logic                minus_switch_level_i = 1'b1;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ActionW-1:0]  action_o;
  logic                source_unit_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic [GainW-1:0]          cfg_gain = GainReset;
  logic signed [OffsetW-1:0] cfg_offset = OffsetReset;
  logic [TicksW-1:0]         cfg_long = LongReset;
  logic [TicksW-1:0]         cfg_long_long = LongLongReset;
  logic [PosW-1:0]           cfg_rel = RelPosReset;
  btn_e                      hist [HistoryDepth];
  logic [TicksW-1:0]         hold_cnt = HoldReset;

  gesture_evt_t pending_events [$];
  int           err_count = 0;
  int           beats_sent = 0;
  bit           send_no_idle = 1'b0;
  bit           recv_no_idle = 1'b0;
  int           hold_req_cnt = 0;
  int           hold_ack_cnt = 0;
  int           recv_wait_left = 0;
  int           recv_hold_left = 0;

  tick_row_t directed_rows [25] = '{
    '{12'(SOpen),   1'b1, 1'b1, ROW_NO_EVENT, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b0, 1'b1, ROW_EVENT,    ACT_PLUS,   1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SPlus),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SD),      1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b0, ROW_EVENT,    ACT_MINUS,  1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SMinus),  1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b0, 1'b0, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SCenter), 1'b0, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SCenter), 1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SCenter), 1'b1, 1'b0, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0},
    '{12'(SOpen),   1'b1, 1'b1, ROW_BY_MODEL, ACT_SINGLE, 1'b0}
  };

  phase_cfg_t fixed_phases [6] = '{
    '{3350, -50,  10, 30,  8, 120},
    '{8191, 511,   1,  2,  4,  80},
    '{0,   -512,  61, 62, 29,  40},
    '{4095,   0,  63,  0, 31,  80},
    '{6000, -200,  3,  6, 30,  80},
    '{2500, -100, 61, 62,  4, 120}
  };

  button_gesture_recognizer uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .adc_sample_i        (adc_sample_i),
    .plus_switch_level_i (plus_switch_level_i),
    .minus_switch_level_i(minus_switch_level_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .action_o            (action_o),
    .source_unit_o       (source_unit_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic btn_e band_of(logic [SampleW-1:0] s);
    logic [31:0] prod;
    int          mv;
    prod = {20'd0, s} * {19'd0, cfg_gain};
    mv = int'(prod >> AdcShift) + int'(cfg_offset);
    if (mv < int'(CenterHi)) return BTN_CENTER;
    if (mv >= int'(DLo) && mv < int'(DHi)) return BTN_D;
    if (mv >= int'(PlusLo) && mv < int'(PlusHi)) return BTN_PLUS;
    if (mv >= int'(MinusLo) && mv < int'(MinusHi)) return BTN_MINUS;
    return BTN_OPEN;
  endfunction

  function automatic void wipe_history();
    foreach (hist[i]) hist[i] = BTN_OPEN;
  endfunction

  function automatic void bump_hold();
    if (hold_cnt < HoldMax) hold_cnt++;
  endfunction

  function automatic int count_clicks();
    int n;
    bit fallen;
    n = 0;
    fallen = 1'b0;
    for (int i = 0; i < ClickQuiet; i++) begin
      if (hist[i] != BTN_OPEN) return 0;
    end
    for (int i = ClickQuiet; i < HistoryDepth; i++) begin
      if (!fallen && hist[i-1] == BTN_OPEN && hist[i] == BTN_CENTER) begin
        fallen = 1'b1;
      end else if (fallen && hist[i-1] == BTN_CENTER && hist[i] == BTN_OPEN) begin
        n++;
        fallen = 1'b0;
      end
    end
    if (n > 0) wipe_history();
    return n;
  endfunction

  function automatic void recognize_tick(input logic [SampleW-1:0] s, input logic p,
                                         input logic m, output bit fire,
                                         output gesture_evt_t ev);
    btn_e hp;
    btn_e sw;
    btn_e btn;
    int   c;
    hp = band_of(s);
    if (!p) sw = BTN_PLUS;
    else if (!m) sw = BTN_MINUS;
    else sw = BTN_OPEN;
    if (hp == BTN_CENTER) btn = BTN_CENTER;
    else if (hp == BTN_D) btn = BTN_D;
    else if (hp == BTN_PLUS || sw == BTN_PLUS) btn = BTN_PLUS;
    else if (hp == BTN_MINUS || sw == BTN_MINUS) btn = BTN_MINUS;
    else btn = BTN_OPEN;
    ev.unit = (btn != sw);
    ev.act = ACT_SINGLE;
    fire = 1'b0;
    if (btn == BTN_OPEN) begin
      if (hold_cnt > cfg_long) wipe_history();
      hold_cnt = '0;
      if (int'(cfg_rel) < HistoryDepth && hist[cfg_rel] == BTN_CENTER) begin
        c = count_clicks();
        if (c == 1) begin
          fire = 1'b1;
          ev.act = ACT_SINGLE;
        end else if (c == 2) begin
          fire = 1'b1;
          ev.act = ACT_DOUBLE;
        end else if (c == 3) begin
          fire = 1'b1;
          ev.act = ACT_TRIPLE;
        end
      end
    end else if (hist[0] == BTN_OPEN) begin
      if (btn == BTN_D || btn == BTN_PLUS) begin
        fire = 1'b1;
        ev.act = ACT_PLUS;
      end else if (btn == BTN_MINUS) begin
        fire = 1'b1;
        ev.act = ACT_MINUS;
      end
    end else if (hold_cnt == cfg_long) begin
      fire = 1'b1;
      if (btn == BTN_CENTER) begin
        ev.act = ACT_LONG;
        bump_hold();
      end else if (btn == BTN_D || btn == BTN_PLUS) begin
        ev.act = ACT_PLUS_LONG;
      end else begin
        ev.act = ACT_MINUS_LONG;
      end
    end else if (hold_cnt == cfg_long_long) begin
      if (btn == BTN_CENTER) begin
        fire = 1'b1;
        ev.act = ACT_LONG_LONG;
      end
      bump_hold();
    end else if (btn == hist[0]) begin
      bump_hold();
    end
    for (int i = HistoryDepth - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = btn;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(btn_e want);
    logic [SampleW-1:0] s;
    logic [SampleW-1:0] start;
    for (int k = 0; k < 24; k++) begin
      s = SampleW'($urandom_range(0, 4095));
      if (band_of(s) == want) return s;
    end
    start = SampleW'($urandom_range(0, 4095));
    for (int k = 0; k < 4096; k++) begin
      s = start + SampleW'(k);
      if (band_of(s) == want) return s;
    end
    return start;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value, int width);
    logic [CfgDataW-1:0] mask;
    logic [CfgDataW-1:0] data;
    mask = CfgDataW'((1 << width) - 1);
    data = (CfgDataW'($urandom) & ~mask) | (CfgDataW'(value) & mask);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ADC_GAIN:      cfg_gain = data[GainW-1:0];
      REG_ADC_OFFSET:    cfg_offset = data[OffsetW-1:0];
      REG_LONG_PUSH:     cfg_long = data[TicksW-1:0];
      REG_LONG_LONG:     cfg_long_long = data[TicksW-1:0];
      REG_RELEASE_CHECK: cfg_rel = data[PosW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(phase_cfg_t pc);
    write_reg(REG_ADC_GAIN, pc.gain, GainW);
    write_reg(REG_ADC_OFFSET, pc.offset, OffsetW);
    write_reg(REG_LONG_PUSH, pc.long_t, TicksW);
    write_reg(REG_LONG_LONG, pc.long_long_t, TicksW);
    write_reg(REG_RELEASE_CHECK, pc.rel_pos, PosW);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_beat(logic [SampleW-1:0] s, logic p, logic m, row_chk_e chk,
                           act_e act, logic unit);
    int           gap;
    bit           fire;
    gesture_evt_t ev;
    gap = send_no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sample_i <= s;
    plus_switch_level_i <= p;
    minus_switch_level_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    recognize_tick(s, p, m, fire, ev);
    case (chk)
      ROW_BY_MODEL: if (fire) pending_events.push_back(ev);
      ROW_EVENT: begin
        ev.act = act;
        ev.unit = unit;
        pending_events.push_back(ev);
      end
      default: ;
    endcase
    beats_sent++;
  endtask

  task automatic press_tick(btn_e want, bit via_switch);
    logic [SampleW-1:0] s;
    logic               p;
    logic               m;
    p = 1'b1;
    m = 1'b1;
    if (via_switch && want == BTN_PLUS) begin
      p = 1'b0;
      m = 1'($urandom);
      s = pick_sample($urandom_range(0, 1) ? BTN_OPEN : BTN_MINUS);
    end else if (via_switch && want == BTN_MINUS) begin
      m = 1'b0;
      s = pick_sample(BTN_OPEN);
    end else begin
      s = pick_sample(want);
      if (want == BTN_CENTER || want == BTN_D) begin
        p = 1'($urandom);
        m = 1'($urandom);
      end else if (want == BTN_PLUS) begin
        m = 1'($urandom);
      end
    end
    send_beat(s, p, m, ROW_BY_MODEL, ACT_SINGLE, 1'b0);
  endtask

  task automatic play_gestures(int n);
    int   first;
    int   kind;
    int   len;
    int   cap;
    bit   sw;
    bit   chg;
    btn_e b;
    btn_e b2;
    first = beats_sent;
    while (beats_sent - first < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        repeat ($urandom_range(1, 5)) begin
          repeat ($urandom_range(1, 3)) press_tick(BTN_CENTER, 1'b0);
          repeat ($urandom_range(1, 3)) press_tick(BTN_OPEN, 1'b0);
        end
        repeat (int'(cfg_rel) + $urandom_range(0, 4)) press_tick(BTN_OPEN, 1'b0);
      end else if (kind < 70) begin
        b = btn_e'($urandom_range(1, 4));
        b2 = btn_e'($urandom_range(1, 4));
        sw = (b == BTN_PLUS || b == BTN_MINUS) && $urandom_range(0, 1);
        chg = ($urandom_range(0, 4) == 0);
        cap = (int'(cfg_long) + 4 < 40) ? int'(cfg_long) + 4 : 40;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 75) : $urandom_range(1, cap);
        for (int j = 0; j < len; j++) press_tick((chg && j >= len / 2) ? b2 : b, sw);
        repeat ($urandom_range(1, 3)) press_tick(BTN_OPEN, 1'b0);
      end else if (kind < 85) begin
        b = $urandom_range(0, 1) ? BTN_PLUS : BTN_MINUS;
        sw = 1'($urandom);
        repeat ($urandom_range(1, 2)) press_tick(b, sw);
        repeat ($urandom_range(1, 2)) press_tick(BTN_OPEN, 1'b0);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_beat(SampleW'($urandom), 1'($urandom), 1'($urandom), ROW_BY_MODEL,
                    ACT_SINGLE, 1'b0);
        end
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      recv_hold_left = 300;
    end
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      recv_wait_left = recv_no_idle ? 0 : $urandom_range(0, 19);
    end
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      out_stall_i <= 1'b1;
    end else if (recv_wait_left > 0) begin
      if (out_valid_o === 1'b1) recv_wait_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_events
    gesture_evt_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        note_mismatch("unexpected event, action", int'(action_o), -1);
      end else begin
        want = pending_events.pop_front();
        if (action_o !== want.act) note_mismatch("action", int'(action_o), int'(want.act));
        if (source_unit_o !== want.unit) begin
          note_mismatch("source_unit", int'(source_unit_o), int'(want.unit));
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    phase_cfg_t pc;
    wipe_history();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].sample, directed_rows[i].plus_lvl,
                directed_rows[i].minus_lvl, directed_rows[i].chk,
                directed_rows[i].act, directed_rows[i].unit);
    end
    foreach (fixed_phases[i]) begin
      wait_idle();
      program_regs(fixed_phases[i]);
      play_gestures(fixed_phases[i].beats);
    end

    // hold off the output while plus taps keep coming back to back
    wait_idle();
    hold_req_cnt++;
    send_no_idle = 1'b1;
    repeat (30) begin
      press_tick(BTN_PLUS, 1'b1);
      press_tick(BTN_OPEN, 1'b0);
    end
    send_no_idle = 1'b0;

    for (int k = 0; k < 4; k++) begin
      wait_idle();
      pc.gain = $urandom_range(1500, 8191);
      pc.offset = int'($urandom_range(0, 400)) - 300;
      pc.long_t = $urandom_range(1, 20);
      pc.long_long_t = pc.long_t + $urandom_range(1, 25);
      pc.rel_pos = $urandom_range(4, 29);
      pc.beats = 80;
      program_regs(pc);
      send_no_idle = (k == 3);
      recv_no_idle = (k == 3);
      play_gestures(pc.beats);
    end
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
